>>> rtl/core/mlfq_pkg.sv
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared types and constants for the three-level feedback queue scheduler.
// ----------------------------------------------------------------------------
package mlfq_pkg;

  localparam int unsigned MaxTasks = 32;
  localparam int unsigned IdW      = 5;
  localparam int unsigned BurstW   = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned LevelW   = 2;
  localparam int unsigned CntW     = 6;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // command codes
  localparam logic CmdArrive = 1'b0;
  localparam logic CmdTick   = 1'b1;

  // status codes
  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatActive   = 2'd1;
  localparam logic [1:0] StatZeroBurst = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegQuantumTop    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegQuantumMiddle = 2'd1;
  localparam logic [CfgIdxW-1:0] RegAgingLimit    = 2'd2;

  typedef struct packed {
    logic             command;
    logic [IdW-1:0]   task_id;
    logic [BurstW-1:0] burst_length;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             ran;
    logic [IdW-1:0]   ran_task;
    logic [1:0]       ran_level;
    logic             first_dispatch;
    logic [TimeW-1:0] response_time;
    logic             completed;
    logic [TimeW-1:0] turnaround_time;
    logic [TimeW-1:0] waiting_time;
    logic             preempted;
    logic [TimeW-1:0] time_now;
  } out_item_t;

endpackage

>>> rtl/core/mlfq_if.sv
// ----------------------------------------------------------------------------
// mlfq_in_if / mlfq_out_if
// Valid/ready channels carrying scheduler items and results.
// ----------------------------------------------------------------------------
interface mlfq_in_if;
  logic               valid;
  logic               ready;
  mlfq_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mlfq_out_if;
  logic                valid;
  logic                ready;
  mlfq_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/mlfq_ram.sv
// ----------------------------------------------------------------------------
// mlfq_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module mlfq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> rtl/core/multilevel_feedback_queue_scheduler_core.sv
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler_core
// Three-level feedback queue scheduler driven by arrive and tick items.
// ----------------------------------------------------------------------------
// arrive: answered after its checks when rejected, after its record and queue write when
//   queued, and after also pushing the running task when it preempts; a tick runs the
//   expiry step, the aging scan over the tasks queued at levels 1 and 2, dispatch and run
// throughput: one item at a time, next accepted in the cycle after the result is taken
// per-task records and the queues live in one ram each, read one word a cycle
// reset: clock, cpu and queues clear at once; no clearing pass is needed
module multilevel_feedback_queue_scheduler_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mlfq_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [mlfq_pkg::CfgDataW-1:0]       cfg_data_i,
  mlfq_in_if.sink                             in_if,
  mlfq_out_if.source                          out_if
);
  import mlfq_pkg::*;

  // sequencer states
  localparam logic [3:0] SIdle    = 4'd0;
  localparam logic [3:0] SArrRd   = 4'd1;
  localparam logic [3:0] SArrWr   = 4'd2;
  localparam logic [3:0] SExpRd   = 4'd3;
  localparam logic [3:0] SAgeFet  = 4'd4;
  localparam logic [3:0] SAgeRd   = 4'd5;
  localparam logic [3:0] SAgeDo   = 4'd6;
  localparam logic [3:0] SDisp    = 4'd7;
  localparam logic [3:0] SDispRd  = 4'd8;
  localparam logic [3:0] SRunRd   = 4'd9;
  localparam logic [3:0] SRunDo   = 4'd10;
  localparam logic [3:0] SOut     = 4'd11;
  localparam logic [3:0] SDispFet = 4'd12;

  localparam int unsigned QAw = $clog2(3 * MaxTasks);
  // per-task record: started, level, left, total, arrived, last_active
  localparam int unsigned RecW = 1 + LevelW + 2 * BurstW + 2 * TimeW;

  typedef struct packed {
    logic              started;
    logic [LevelW-1:0] level;
    logic [BurstW-1:0] left;
    logic [BurstW-1:0] total;
    logic [TimeW-1:0]  arrived;
    logic [TimeW-1:0]  last;
  } rec_t;

  logic [3:0] state_q, state_d;

  // configuration
  logic [CfgDataW-1:0] qtop_q, qmid_q, age_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qtop_q <= 16'd8;
      qmid_q <= 16'd16;
      age_q  <= 16'd50;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegQuantumTop:    qtop_q <= cfg_data_i;
        RegQuantumMiddle: qmid_q <= cfg_data_i;
        RegAgingLimit:    age_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // scheduler state
  logic [TimeW-1:0]  clk_q, clk_d;
  logic              busy_q, busy_d;
  logic [IdW-1:0]    cur_q, cur_d;
  logic [BurstW-1:0] slice_q, slice_d;
  logic              exp_q, exp_d;
  logic [MaxTasks-1:0] live_q, live_d;
  logic [IdW-1:0]    head_q [3];
  logic [IdW-1:0]    head_d [3];
  logic [CntW-1:0]   cnt_q [3];
  logic [CntW-1:0]   cnt_d [3];

  // work registers
  in_item_t         item_q, item_d;
  out_item_t        res_q, res_d;
  logic [1:0]       lvl_q, lvl_d;
  logic [CntW-1:0]  n_q, n_d;
  logic [IdW-1:0]   tid_q, tid_d;

  // memories
  logic             rec_we;
  logic [IdW-1:0]   rec_waddr, rec_raddr;
  rec_t             rec_wdata, rec_rdata;
  logic             q_we;
  logic [QAw-1:0]   q_waddr, q_raddr;
  logic [IdW-1:0]   q_wdata, q_rdata;

  mlfq_ram #(.Width(RecW), .Depth(MaxTasks)) u_rec (
    .clk_i, .we_i(rec_we), .waddr_i(rec_waddr), .wdata_i(rec_wdata),
    .raddr_i(rec_raddr), .rdata_o(rec_rdata)
  );
  mlfq_ram #(.Width(IdW), .Depth(3 * MaxTasks)) u_fifo (
    .clk_i, .we_i(q_we), .waddr_i(q_waddr), .wdata_i(q_wdata),
    .raddr_i(q_raddr), .rdata_o(q_rdata)
  );

  // queue slot address: level base plus ring index
  function automatic logic [QAw-1:0] qaddr(logic [1:0] l, logic [IdW-1:0] idx);
    logic [QAw-1:0] base;
    base = QAw'(l) * QAw'(MaxTasks);
    return base + QAw'(idx);
  endfunction

  function automatic logic [IdW-1:0] tail(logic [IdW-1:0] h, logic [CntW-1:0] c);
    return h + c[IdW-1:0];
  endfunction

  logic [TimeW-1:0] ta;
  logic [BurstW-1:0] left_m1;

  assign in_if.ready  = (state_q == SIdle);
  assign out_if.valid = (state_q == SOut);
  assign out_if.data  = res_q;

  // sequencer
  always_comb begin
    state_d = state_q; clk_d = clk_q; busy_d = busy_q; cur_d = cur_q;
    slice_d = slice_q; exp_d = exp_q; live_d = live_q;
    head_d = head_q; cnt_d = cnt_q;
    item_d = item_q; res_d = res_q; lvl_d = lvl_q; n_d = n_q; tid_d = tid_q;
    rec_we = 1'b0; rec_waddr = cur_q; rec_raddr = cur_q; rec_wdata = rec_rdata;
    q_we = 1'b0; q_waddr = '0; q_wdata = cur_q;
    q_raddr = qaddr(lvl_q, head_q[lvl_q]);
    ta = clk_q - rec_rdata.arrived;
    left_m1 = rec_rdata.left - 16'd1;

    case (state_q)
      SIdle: begin
        if (in_if.valid) begin
          item_d = in_if.data;
          res_d = '0;
          if (in_if.data.command == CmdArrive) begin
            state_d = SArrRd;
          end else begin
            state_d = SExpRd;
          end
        end
      end
      // arrive: reject an active task or a zero burst, else read running task record for its level
      SArrRd: begin
        if (live_q[item_q.task_id]) begin
          res_d.status = StatActive;
          state_d = SOut;
        end else if (item_q.burst_length == '0) begin
          res_d.status = StatZeroBurst;
          state_d = SOut;
        end else begin
          state_d = SArrWr;
        end
      end
      SArrWr: begin
        rec_we = 1'b1;
        rec_waddr = item_q.task_id;
        rec_wdata = '{started: 1'b0, level: '0, left: item_q.burst_length,
                      total: item_q.burst_length, arrived: clk_q, last: clk_q};
        live_d[item_q.task_id] = 1'b1;
        q_we = 1'b1;
        q_waddr = qaddr(2'd0, tail(head_q[0], cnt_q[0]));
        q_wdata = item_q.task_id;
        cnt_d[0] = cnt_q[0] + 1'b1;
        if (busy_q && rec_rdata.level != '0 && cur_q != item_q.task_id) begin
          state_d = SDispFet;
          lvl_d = rec_rdata.level;
        end else begin
          state_d = SOut;
        end
      end
      // second write step of a preemption: push running task
      SDispFet: begin
        q_we = 1'b1;
        q_waddr = qaddr(lvl_q, tail(head_q[lvl_q], cnt_q[lvl_q]));
        q_wdata = cur_q;
        cnt_d[lvl_q] = cnt_q[lvl_q] + 1'b1;
        busy_d = 1'b0;
        exp_d = 1'b0;
        res_d.preempted = 1'b1;
        state_d = SOut;
      end
      // tick: pending expiry, record of running task is now valid
      SExpRd: begin
        state_d = SAgeFet;
        lvl_d = 2'd1;
        n_d = cnt_q[1];
        if (exp_q && busy_q) begin
          rec_we = 1'b1;
          rec_wdata = rec_rdata;
          rec_wdata.level = (rec_rdata.level < 2'd2) ? rec_rdata.level + 2'd1 : 2'd2;
          q_we = 1'b1;
          q_waddr = qaddr(rec_wdata.level, tail(head_q[rec_wdata.level],
                                                cnt_q[rec_wdata.level]));
          cnt_d[rec_wdata.level] = cnt_q[rec_wdata.level] + 1'b1;
          busy_d = 1'b0;
          if (rec_wdata.level == 2'd1) n_d = cnt_q[1] + 1'b1;
        end
        exp_d = 1'b0;
      end
      // aging scan: pop head, look up its record, requeue it at level 0 if aged, else at its level
      SAgeFet: begin
        if (n_q == '0) begin
          if (lvl_q == 2'd1) begin
            lvl_d = 2'd2;
            n_d = cnt_q[2];
          end else begin
            state_d = SDisp;
          end
        end else begin
          state_d = SAgeRd;
        end
      end
      SAgeRd: begin
        tid_d = q_rdata;
        rec_raddr = q_rdata;
        head_d[lvl_q] = head_q[lvl_q] + 1'b1;
        cnt_d[lvl_q] = cnt_q[lvl_q] - 1'b1;
        state_d = SAgeDo;
      end
      SAgeDo: begin
        q_we = 1'b1;
        q_wdata = tid_q;
        n_d = n_q - 1'b1;
        state_d = SAgeFet;
        if ((clk_q - rec_rdata.last) >= TimeW'(age_q)) begin
          rec_we = 1'b1;
          rec_waddr = tid_q;
          rec_wdata = rec_rdata;
          rec_wdata.level = '0;
          rec_wdata.last = clk_q;
          q_waddr = qaddr(2'd0, tail(head_q[0], cnt_q[0]));
          cnt_d[0] = cnt_q[0] + 1'b1;
        end else begin
          q_waddr = qaddr(lvl_q, tail(head_q[lvl_q], cnt_q[lvl_q]));
          cnt_d[lvl_q] = cnt_q[lvl_q] + 1'b1;
        end
      end
      // dispatch: when no task is running, choose highest nonempty level
      SDisp: begin
        state_d = SRunRd;
        if (!busy_q) begin
          if (cnt_q[0] != '0) begin
            lvl_d = 2'd0; state_d = SDispRd;
          end else if (cnt_q[1] != '0) begin
            lvl_d = 2'd1; state_d = SDispRd;
          end else if (cnt_q[2] != '0) begin
            lvl_d = 2'd2; state_d = SDispRd;
          end
        end
        // head read of the chosen level
        q_raddr = qaddr(lvl_d, head_q[lvl_d]);
      end
      SDispRd: begin
        cur_d = q_rdata;
        head_d[lvl_q] = head_q[lvl_q] + 1'b1;
        cnt_d[lvl_q] = cnt_q[lvl_q] - 1'b1;
        busy_d = 1'b1;
        slice_d = '0;
        state_d = SRunRd;
      end
      // record read issued at cur_q
      SRunRd: begin
        state_d = SRunDo;
      end
      SRunDo: begin
        clk_d = clk_q + 1'b1;
        state_d = SOut;
        if (busy_q) begin
          rec_we = 1'b1;
          rec_wdata = rec_rdata;
          res_d.ran = 1'b1;
          res_d.ran_task = cur_q;
          res_d.ran_level = rec_rdata.level;
          if (!rec_rdata.started) begin
            rec_wdata.started = 1'b1;
            res_d.first_dispatch = 1'b1;
            res_d.response_time = clk_q - rec_rdata.arrived;
          end
          rec_wdata.left = left_m1;
          rec_wdata.last = clk_q + 1'b1;
          if (slice_q != 16'hFFFF) slice_d = slice_q + 1'b1;
          if (left_m1 == '0) begin
            res_d.completed = 1'b1;
            res_d.turnaround_time = ta + 1'b1;
            res_d.waiting_time = ((ta + 1'b1) > TimeW'(rec_rdata.total)) ?
                                 (ta + 1'b1 - TimeW'(rec_rdata.total)) : '0;
            live_d[cur_q] = 1'b0;
            busy_d = 1'b0;
          end else if (rec_rdata.level < 2'd2) begin
            if (slice_d == ((rec_rdata.level == '0) ? qtop_q : qmid_q)) exp_d = 1'b1;
          end
        end
      end
      SOut: begin
        res_d.time_now = clk_q;
        if (out_if.ready) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
    // time stamp is always current
    if (state_q != SOut) res_d.time_now = clk_d;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; clk_q <= '0; busy_q <= 1'b0; cur_q <= '0;
      slice_q <= '0; exp_q <= 1'b0; live_q <= '0;
      for (int i = 0; i < 3; i++) begin
        head_q[i] <= '0; cnt_q[i] <= '0;
      end
    end else begin
      state_q <= state_d; clk_q <= clk_d; busy_q <= busy_d; cur_q <= cur_d;
      slice_q <= slice_d; exp_q <= exp_d; live_q <= live_d;
      head_q <= head_d; cnt_q <= cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q <= item_d; res_q <= res_d; lvl_q <= lvl_d; n_q <= n_d;
    tid_q <= tid_d;
  end
endmodule
